// ----- design/scst_pkg.sv -----
// Shared types, codes and constants for the sensor clock tracker.
package scst_pkg;

    // Fixed-point layout and loop constants.
    localparam int TIME_FRAC_BITS = 16;
    localparam int MIN_ANCHORS    = 4;
    localparam int DIV_STEPS      = 96;
    localparam int CFG_DATA_W     = 48;
    localparam int CFG_IDX_W      = 3;

    localparam logic [32:0] GAIN_ONE       = 33'h1_0000_0000;
    localparam logic [32:0] VAR_GAIN_FLOOR = 33'd42949673;
    localparam logic [47:0] MASK48         = 48'hFFFF_FFFF_FFFF;

    // Register values after reset.
    localparam logic [5:0]  RST_COUNTER_BITS = 6'd32;
    localparam logic [47:0] RST_NOMINAL_TICK = 48'h0001_0000_0000;
    localparam logic [31:0] RST_MIN_SCALE    = 32'd1030792151;
    localparam logic [31:0] RST_MAX_SCALE    = 32'd1116691497;
    localparam logic [31:0] RST_PHASE_TC     = 32'd1000000;
    localparam logic [31:0] RST_RATE_TC      = 32'd10000000;
    localparam logic [31:0] RST_MIN_GAP      = 32'd10000;
    localparam logic [31:0] RST_RESID_LIMIT  = 32'd1000;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_NONMONO   = 3'd2,
        ST_INTERVAL  = 3'd3,
        ST_SLOPE     = 3'd4,
        ST_RESIDUAL  = 3'd5,
        ST_WRAP      = 3'd6,
        ST_RANGE     = 3'd7
    } t_status;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_UNWRAP = 2'd0,
        REQ_ANCHOR = 2'd1,
        REQ_MAP    = 2'd2
    } t_req;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNTER_BITS = 3'd0,
        CFG_NOMINAL_TICK = 3'd1,
        CFG_MIN_SCALE    = 3'd2,
        CFG_MAX_SCALE    = 3'd3,
        CFG_PHASE_TC     = 3'd4,
        CFG_RATE_TC      = 3'd5,
        CFG_MIN_GAP      = 3'd6,
        CFG_RESID_LIMIT  = 3'd7
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_UNWRAP,
        S_AN_CHK,
        S_AN_IVL,
        S_AN_OBS,
        S_AN_LO,
        S_AN_HI,
        S_AN_PRED,
        S_AN_RES,
        S_AN_RSQ,
        S_AN_RG,
        S_AN_PG,
        S_AN_SL,
        S_AN_ADJ,
        S_AN_VAR,
        S_MAP,
        S_MAP_M,
        S_MAP_R,
        S_DONE
    } t_state;

    // Command to the shared multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    // Command to the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_STEPS-1:0] num;
        logic [127:0]         den;
    } t_div_req;

endpackage

// ----- design/scst_req_if.sv -----
// Request channel: valid, ready and the request fields.
interface scst_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] raw_cnt;
    logic [63:0] ext_tick;
    logic [63:0] anchor_us;
    logic [63:0] latest_allowed_us;

    modport source (output valid, req_type, raw_cnt, ext_tick, anchor_us,
                    latest_allowed_us, input ready);
    modport sink   (input valid, req_type, raw_cnt, ext_tick, anchor_us,
                    latest_allowed_us, output ready);
endinterface

// ----- design/scst_res_if.sv -----
// Result channel: valid, ready and the result fields.
interface scst_res_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [2:0]  status;
    logic [63:0] value;

    modport source (output valid, ok, status, value, input ready);
    modport sink   (input valid, ok, status, value, output ready);
endinterface

// ----- design/sensor_clock_sync_tracker.sv -----
// An anchor runs three 96-step divisions in the shared restoring divider and eight multiplies
// in the shared 64x64 multiplier; one transaction at a time. The block is ready again the
// cycle after the result is loaded into the output register; a full output register stalls it.
// Synchronous active-low reset restores the configuration defaults and the tracking
// state (slope to the nominal tick, everything else zero); no clearing pass is needed.
module sensor_clock_sync_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    scst_req_if.sink                          i_req,
    scst_res_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [scst_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [scst_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import scst_pkg::*;

    localparam int F = TIME_FRAC_BITS;

    // Configuration registers.
    logic [5:0]  r_cfg_bits;
    logic [47:0] r_nominal;
    logic [31:0] r_min_scale, r_max_scale, r_ptc, r_rtc, r_gap, r_rlim;

    // Tracking state.
    logic        r_unwrap_started, n_unwrap_started;
    logic [63:0] r_last_unwrapped, n_last_unwrapped;
    logic        r_ref_started, n_ref_started;
    logic [63:0] r_ref_tick, n_ref_tick;
    logic [63:0] r_ref_time, n_ref_time;
    logic [63:0] r_anchor_tick, n_anchor_tick;
    logic [63:0] r_anchor_time, n_anchor_time;
    logic [47:0] r_slope, n_slope;
    logic [47:0] r_var, n_var;
    logic [31:0] r_count, n_count;

    // Sequencer and working registers.
    t_state       r_state, n_state;
    logic [31:0]  r_raw, n_raw;
    logic [63:0]  r_tick, n_tick;
    logic [63:0]  r_host, n_host;
    logic [63:0]  r_bound, n_bound;
    logic [111:0] r_interval, n_interval;
    logic [63:0]  r_obs, n_obs;
    logic [63:0]  r_lo_s, n_lo_s;
    logic [63:0]  r_hi_s, n_hi_s;
    logic [127:0] r_pred, n_pred;
    logic         r_neg, n_neg;
    logic [127:0] r_mag, n_mag;
    logic         r_gated, n_gated;
    logic [127:0] r_sq, n_sq;
    logic [32:0]  r_rg, n_rg;
    logic [32:0]  r_pg, n_pg;
    logic         r_ge, n_ge;
    logic [127:0] r_m, n_m;
    t_status      r_status, n_status;
    logic [63:0]  r_value, n_value;

    // Output register.
    logic         r_ov, n_ov;
    logic         r_out_ok, n_out_ok;
    t_status      r_out_status, n_out_status;
    logic [63:0]  r_out_value, n_out_value;

    // Shared units.
    t_mul_req               mul_req;
    logic                   mul_done;
    logic [127:0]           mul_prod;
    t_div_req               div_req;
    logic                   div_done;
    logic [DIV_STEPS-1:0]   div_quo;

    scst_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    scst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Loop gain from the quotient; a zero denominator gives unity gain.
    function automatic logic [32:0] f_gain(logic [127:0] den, logic [DIV_STEPS-1:0] quo);
        if (den == '0) begin
            return GAIN_ONE;
        end
        return GAIN_ONE - quo[32:0];
    endfunction

    // Datapath terms shared by several states.
    logic [5:0]   bits_c;
    logic [32:0]  modulus;
    logic [31:0]  mask32, half, raw_m, delta;
    logic [63:0]  host_q, dt, host_gap, hi_now;
    logic [127:0] den_r, den_p, thresh, vt, msum, m2, span;
    logic [48:0]  v1;
    logic [51:0]  v9;
    logic [63:0]  sdiff, step, snew, rsqf, vdiff, tick_diff;
    logic [32:0]  vg;
    logic [127:0] tsum;

    always_comb begin
        bits_c   = (r_cfg_bits < 6'd2) ? 6'd2 : ((r_cfg_bits > 6'd32) ? 6'd32 : r_cfg_bits);
        modulus  = 33'd1 << bits_c;
        mask32   = 32'(modulus - 33'd1);
        half     = 32'(modulus >> 1);
        raw_m    = r_raw & mask32;
        delta    = (raw_m - (r_last_unwrapped[31:0] & mask32)) & mask32;
        host_q   = r_host << F;
        dt       = r_tick - r_anchor_tick;
        host_gap = r_host - r_anchor_time;
        hi_now   = 64'(mul_prod >> 30);
        den_r    = {16'd0, r_interval} + {64'd0, r_rtc, 32'd0};
        den_p    = {16'd0, r_interval} + {64'd0, r_ptc, 32'd0};
        v1       = {1'b0, r_var} + 49'(64'd1 << F);
        v9       = {v1, 3'b000} + {3'b000, v1};
        thresh   = 128'(v9) << F;
        sdiff    = (r_obs >= {16'd0, r_slope}) ? r_obs - {16'd0, r_slope}
                                               : {16'd0, r_slope} - r_obs;
        step     = 64'(mul_prod >> 32);
        rsqf     = ((r_sq >> F) > 128'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : 64'(r_sq >> F);
        vg       = (r_pg < VAR_GAIN_FLOOR) ? VAR_GAIN_FLOOR : r_pg;
        vdiff    = (rsqf >= {16'd0, r_var}) ? rsqf - {16'd0, r_var} : {16'd0, r_var} - rsqf;
        vt       = 128'(r_var) + (mul_prod >> 32);
        tick_diff = (r_tick >= r_ref_tick) ? r_tick - r_ref_tick : r_ref_tick - r_tick;
        span     = mul_prod >> (32 - F);
        msum     = r_m + (128'd1 << (F - 1));
        m2       = msum >> F;
        // Slope update before the bound clamp.
        if (r_obs >= {16'd0, r_slope}) begin
            snew = {16'd0, r_slope} + step;
        end else begin
            snew = {16'd0, r_slope} - step;
        end
        if (snew < r_lo_s) begin
            snew = r_lo_s;
        end else if (snew > r_hi_s) begin
            snew = r_hi_s;
        end
        tsum = r_neg ? r_pred - 128'(step) : r_pred + 128'(step);
    end

    // Sequencer: next state, next register values and unit commands.
    always_comb begin
        n_state          = r_state;
        n_unwrap_started = r_unwrap_started;
        n_last_unwrapped = r_last_unwrapped;
        n_ref_started    = r_ref_started;
        n_ref_tick       = r_ref_tick;
        n_ref_time       = r_ref_time;
        n_anchor_tick    = r_anchor_tick;
        n_anchor_time    = r_anchor_time;
        n_slope          = r_slope;
        n_var            = r_var;
        n_count          = r_count;
        n_raw            = r_raw;
        n_tick           = r_tick;
        n_host           = r_host;
        n_bound          = r_bound;
        n_interval       = r_interval;
        n_obs            = r_obs;
        n_lo_s           = r_lo_s;
        n_hi_s           = r_hi_s;
        n_pred           = r_pred;
        n_neg            = r_neg;
        n_mag            = r_mag;
        n_gated          = r_gated;
        n_sq             = r_sq;
        n_rg             = r_rg;
        n_pg             = r_pg;
        n_ge             = r_ge;
        n_m              = r_m;
        n_status         = r_status;
        n_value          = r_value;
        n_ov             = r_ov && !o_res.ready;
        n_out_ok         = r_out_ok;
        n_out_status     = r_out_status;
        n_out_value      = r_out_value;
        mul_req          = '0;
        div_req          = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_raw    = i_req.raw_cnt;
                    n_tick   = i_req.ext_tick;
                    n_host   = i_req.anchor_us;
                    n_bound  = i_req.latest_allowed_us;
                    n_status = ST_OK;
                    n_value  = '0;
                    case (t_req'(i_req.req_type))
                        REQ_UNWRAP: n_state = S_UNWRAP;
                        REQ_ANCHOR: n_state = S_AN_CHK;
                        REQ_MAP:    n_state = S_MAP;
                        default: begin
                            n_status = ST_INVALID;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end

            // Extend the raw counter, refusing a step of half the modulus or more.
            S_UNWRAP: begin
                n_state = S_DONE;
                if (!r_unwrap_started) begin
                    n_unwrap_started = 1'b1;
                    n_last_unwrapped = 64'(raw_m);
                    n_value          = 64'(raw_m);
                end else if (delta >= half) begin
                    n_status = ST_WRAP;
                end else begin
                    n_last_unwrapped = r_last_unwrapped + 64'(delta);
                    n_value          = r_last_unwrapped + 64'(delta);
                end
            end

            // Anchor validity, seeding and the interval multiply.
            S_AN_CHK: begin
                if (r_host == '0) begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end else if ((r_host >> (64 - F)) != '0) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else if (!r_ref_started) begin
                    n_ref_started = 1'b1;
                    n_ref_tick    = r_tick;
                    n_anchor_tick = r_tick;
                    n_anchor_time = r_host;
                    n_ref_time    = host_q;
                    n_slope       = r_nominal;
                    n_count       = 32'd1;
                    n_state       = S_DONE;
                end else if (r_tick <= r_anchor_tick || r_host <= r_anchor_time) begin
                    n_status = ST_NONMONO;
                    n_state  = S_DONE;
                end else begin
                    mul_req.start = 1'b1;
                    mul_req.a     = dt;
                    mul_req.b     = {16'd0, r_nominal};
                    n_state       = S_AN_IVL;
                end
            end

            // Minimum gap, then the observed slope division.
            S_AN_IVL: begin
                if (mul_done) begin
                    n_interval = mul_prod[111:0];
                    if (mul_prod[111:0] < {48'd0, r_gap, 32'd0}) begin
                        n_status = ST_INTERVAL;
                        n_state  = S_DONE;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = {host_gap, 32'd0};
                        div_req.den   = {64'd0, dt};
                        n_state       = S_AN_OBS;
                    end
                end
            end

            S_AN_OBS: begin
                if (div_done) begin
                    n_obs = div_quo[63:0];
                    if (div_quo[DIV_STEPS-1:64] != '0) begin
                        n_status = ST_SLOPE;
                        n_state  = S_DONE;
                    end else begin
                        mul_req.start = 1'b1;
                        mul_req.a     = {16'd0, r_nominal};
                        mul_req.b     = {32'd0, r_min_scale};
                        n_state       = S_AN_LO;
                    end
                end
            end

            S_AN_LO: begin
                if (mul_done) begin
                    n_lo_s        = hi_now;
                    mul_req.start = 1'b1;
                    mul_req.a     = {16'd0, r_nominal};
                    mul_req.b     = {32'd0, r_max_scale};
                    n_state       = S_AN_HI;
                end
            end

            // Slope bounds check, then the phase prediction multiply.
            S_AN_HI: begin
                if (mul_done) begin
                    n_hi_s = hi_now;
                    if (r_obs < r_lo_s || r_obs > hi_now) begin
                        n_status = ST_SLOPE;
                        n_state  = S_DONE;
                    end else begin
                        mul_req.start = 1'b1;
                        mul_req.a     = r_tick - r_ref_tick;
                        mul_req.b     = {16'd0, r_slope};
                        n_state       = S_AN_PRED;
                    end
                end
            end

            S_AN_PRED: begin
                if (mul_done) begin
                    n_pred  = (mul_prod >> (32 - F)) + 128'(r_ref_time);
                    n_state = S_AN_RES;
                end
            end

            // Residual magnitude against the start limit.
            S_AN_RES: begin
                n_neg = (128'(host_q) < r_pred);
                n_mag = n_neg ? r_pred - 128'(host_q) : 128'(host_q) - r_pred;
                n_gated = (n_mag > (128'(r_rlim) << F));
                if (n_gated && (r_count < 32'(MIN_ANCHORS) || n_mag[127:64] != '0)) begin
                    n_status = ST_RESIDUAL;
                    n_state  = S_DONE;
                end else begin
                    mul_req.start = 1'b1;
                    mul_req.a     = n_mag[63:0];
                    mul_req.b     = n_mag[63:0];
                    n_state       = S_AN_RSQ;
                end
            end

            // Learned limit as a squared compare, then the rate gain division.
            S_AN_RSQ: begin
                if (mul_done) begin
                    n_sq = mul_prod;
                    if (r_gated && mul_prod > thresh) begin
                        n_status = ST_RESIDUAL;
                        n_state  = S_DONE;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = {r_rtc, 64'd0};
                        div_req.den   = den_r;
                        n_state       = S_AN_RG;
                    end
                end
            end

            S_AN_RG: begin
                if (div_done) begin
                    n_rg          = f_gain(den_r, div_quo);
                    div_req.start = 1'b1;
                    div_req.num   = {r_ptc, 64'd0};
                    div_req.den   = den_p;
                    n_state       = S_AN_PG;
                end
            end

            S_AN_PG: begin
                if (div_done) begin
                    n_pg          = f_gain(den_p, div_quo);
                    mul_req.start = 1'b1;
                    mul_req.a     = 64'(r_rg);
                    mul_req.b     = sdiff;
                    n_state       = S_AN_SL;
                end
            end

            // Slope update, then the phase correction multiply.
            S_AN_SL: begin
                if (mul_done) begin
                    n_slope       = (snew > 64'(MASK48)) ? MASK48 : snew[47:0];
                    mul_req.start = 1'b1;
                    mul_req.a     = 64'(r_pg);
                    mul_req.b     = r_mag[63:0];
                    n_state       = S_AN_ADJ;
                end
            end

            // Phase update and reference move, then the variance multiply.
            S_AN_ADJ: begin
                if (mul_done) begin
                    n_ref_time    = (tsum[127:64] != '0) ? '1 : tsum[63:0];
                    n_ref_tick    = r_tick;
                    n_anchor_tick = r_tick;
                    n_anchor_time = r_host;
                    mul_req.start = 1'b1;
                    mul_req.a     = 64'(vg);
                    mul_req.b     = vdiff;
                    n_state       = S_AN_VAR;
                end
            end

            S_AN_VAR: begin
                if (mul_done) begin
                    if (rsqf >= {16'd0, r_var}) begin
                        n_var = (vt > 128'(MASK48)) ? MASK48 : vt[47:0];
                    end else begin
                        n_var = r_var - step[47:0];
                    end
                    if (r_count != '1) begin
                        n_count = r_count + 32'd1;
                    end
                    n_state = S_DONE;
                end
            end

            // Map: scaled tick distance from the reference.
            S_MAP: begin
                if (!r_ref_started) begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end else begin
                    n_ge          = (r_tick >= r_ref_tick);
                    mul_req.start = 1'b1;
                    mul_req.a     = tick_diff;
                    mul_req.b     = {16'd0, r_slope};
                    n_state       = S_MAP_M;
                end
            end

            S_MAP_M: begin
                if (mul_done) begin
                    if (r_ge) begin
                        n_m     = 128'(r_ref_time) + span;
                        n_state = S_MAP_R;
                    end else if (span > 128'(r_ref_time)) begin
                        n_status = ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        n_m     = 128'(r_ref_time) - span;
                        n_state = S_MAP_R;
                    end
                end
            end

            // Round to whole microseconds and apply the upper bound.
            S_MAP_R: begin
                n_state = S_DONE;
                if (r_m < (128'd1 << (F - 1)) || m2[127:64] != '0 || m2[63:0] > r_bound) begin
                    n_status = ST_RANGE;
                end else begin
                    n_value = m2[63:0];
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_ov || o_res.ready) begin
                    n_ov         = 1'b1;
                    n_out_ok     = (r_status == ST_OK);
                    n_out_status = r_status;
                    n_out_value  = (r_status == ST_OK) ? r_value : '0;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State register and configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_ov             <= 1'b0;
            r_cfg_bits       <= RST_COUNTER_BITS;
            r_nominal        <= RST_NOMINAL_TICK;
            r_min_scale      <= RST_MIN_SCALE;
            r_max_scale      <= RST_MAX_SCALE;
            r_ptc            <= RST_PHASE_TC;
            r_rtc            <= RST_RATE_TC;
            r_gap            <= RST_MIN_GAP;
            r_rlim           <= RST_RESID_LIMIT;
            r_unwrap_started <= 1'b0;
            r_last_unwrapped <= '0;
            r_ref_started    <= 1'b0;
            r_ref_tick       <= '0;
            r_ref_time       <= '0;
            r_anchor_tick    <= '0;
            r_anchor_time    <= '0;
            r_slope          <= RST_NOMINAL_TICK;
            r_var            <= '0;
            r_count          <= '0;
        end else begin
            r_state          <= n_state;
            r_ov             <= n_ov;
            r_unwrap_started <= n_unwrap_started;
            r_last_unwrapped <= n_last_unwrapped;
            r_ref_started    <= n_ref_started;
            r_ref_tick       <= n_ref_tick;
            r_ref_time       <= n_ref_time;
            r_anchor_tick    <= n_anchor_tick;
            r_anchor_time    <= n_anchor_time;
            r_slope          <= n_slope;
            r_var            <= n_var;
            r_count          <= n_count;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_COUNTER_BITS: r_cfg_bits  <= i_cfg_data[5:0];
                    CFG_NOMINAL_TICK: r_nominal   <= i_cfg_data[47:0];
                    CFG_MIN_SCALE:    r_min_scale <= i_cfg_data[31:0];
                    CFG_MAX_SCALE:    r_max_scale <= i_cfg_data[31:0];
                    CFG_PHASE_TC:     r_ptc       <= i_cfg_data[31:0];
                    CFG_RATE_TC:      r_rtc       <= i_cfg_data[31:0];
                    CFG_MIN_GAP:      r_gap       <= i_cfg_data[31:0];
                    CFG_RESID_LIMIT:  r_rlim      <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge i_clk) begin
        r_raw        <= n_raw;
        r_tick       <= n_tick;
        r_host       <= n_host;
        r_bound      <= n_bound;
        r_interval   <= n_interval;
        r_obs        <= n_obs;
        r_lo_s       <= n_lo_s;
        r_hi_s       <= n_hi_s;
        r_pred       <= n_pred;
        r_neg        <= n_neg;
        r_mag        <= n_mag;
        r_gated      <= n_gated;
        r_sq         <= n_sq;
        r_rg         <= n_rg;
        r_pg         <= n_pg;
        r_ge         <= n_ge;
        r_m          <= n_m;
        r_status     <= n_status;
        r_value      <= n_value;
        r_out_ok     <= n_out_ok;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    // Ports.
    assign i_req.ready  = (r_state == S_IDLE);
    assign o_res.valid  = r_ov;
    assign o_res.ok     = r_out_ok;
    assign o_res.status = r_out_status;
    assign o_res.value  = r_out_value;
endmodule

// ----- design/scst_mul.sv -----
// Shared 64x64 multiplier built from four passes of one 32x32 multiplier.
module scst_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scst_pkg::t_mul_req i_req,
    output logic               o_done,
    output logic [127:0]       o_prod
);
    import scst_pkg::*;

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [1:0]   r_idx;
    logic         r_busy;
    logic         r_done;
    logic [127:0] r_acc;
    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pp;
    logic [127:0] ppx;

    // One partial product per pass, weighted by the halves it came from.
    always_comb begin
        pa  = r_idx[0] ? r_a[63:32] : r_a[31:0];
        pb  = r_idx[1] ? r_b[63:32] : r_b[31:0];
        pp  = pa * pb;
        ppx = 128'(pp) << ({6'd0, r_idx[0]} + {6'd0, r_idx[1]}) * 7'd32;
    end

    // Operand capture and accumulation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_idx  <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + ppx;
                r_idx <= r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ----- design/scst_div.sv -----
// Shared restoring divider: one quotient bit per cycle.
module scst_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scst_pkg::t_div_req               i_req,
    output logic                             o_done,
    output logic [scst_pkg::DIV_STEPS-1:0]   o_quo
);
    import scst_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [127:0]           r_rem;
    logic [127:0]           r_den;
    logic [DIV_STEPS-1:0]   r_q;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [127:0]           sh;
    logic                   ge;

    // Bring down the next numerator bit and try a subtract.
    always_comb begin
        sh = {r_rem[126:0], r_q[DIV_STEPS-1]};
        ge = (sh >= r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_q    <= i_req.num;
                r_den  <= i_req.den;
                r_cnt  <= CNT_W'(DIV_STEPS - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? sh - r_den : sh;
                r_q   <= {r_q[DIV_STEPS-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule
